>>> sv/buffer_pool_frame_manager_top_assert.svh
// Assertion macros for the frame manager.
// Used by bpfm_ctrl and the top level; no other dependencies.
`ifndef BUFFER_POOL_FRAME_MANAGER_TOP_ASSERT_SVH
`define BUFFER_POOL_FRAME_MANAGER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BPFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl failed");
`define BPFM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define BPFM_ASSERT(lbl, prop)
`define BPFM_ASSERT_RST(lbl, prop)
`endif
`endif

>>> sv/bpfm_pkg.sv
// Shared types and constants of the buffer pool frame manager.
// No dependencies.
package bpfm_pkg;
  localparam int POOL_FRAMES_DEF = 16;
  localparam int PIN_BITS_DEF = 16;
  localparam int PAGE_W = 32;
  localparam int STATUS_W = 3;
  localparam int MODE_W = 3;
  localparam int FIDX_W = 4;

  localparam logic [MODE_W-1:0] MODE_FETCH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNPIN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_RES  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PINNED   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_OUT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   frame_index;
    logic                was_hit;
    logic                writeback_valid;
    logic [PAGE_W-1:0]   writeback_page_id;
    logic                load_from_disk;
    logic                zero_fill;
    logic                remove_from_disk;
  } result_t;
endpackage

>>> sv/buffer_pool_frame_manager_top.sv
// Buffer pool frame manager: LRU page cache bookkeeping with pin counts.
// One request stream in, one result per request out; no configuration registers.
// Each request (fetch, allocate, unpin, flush, delete) is a transaction on in_*.
// The block scans the frame table in its memory once for lookup and victim choice,
// then sweeps it again to rewrite ranks and the chosen frame.
// out_tvalid rises once the scan, the decide state and the update sweep are done;
// one request is in flight at a time, so no new request is taken before the result
// transaction of the last one completes; each pass reads the frame table through
// its single read port.
// in_tready is high only while the block is idle.
// A stalled out_tready holds the result and its payload stable; no new request is
// taken until the result transaction completes.
// Reset marks all frames empty at once through per-frame valid flip-flops; the
// block is ready in the first cycle after reset, with no clearing pass.
// Every request produces exactly one result, including unknown modes (all zero).
`include "buffer_pool_frame_manager_top_assert.svh"
module buffer_pool_frame_manager_top
  import bpfm_pkg::*;
#(
  parameter int POOL_FRAMES = POOL_FRAMES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[2:0], page_id[34:3], mark_dirty[35], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, frame_index, was_hit, writeback_valid,
                                  // writeback_page_id, load_from_disk, zero_fill,
                                  // remove_from_disk, zero pad
);
  result_t r;

  bpfm_ctrl #(.FRAMES(POOL_FRAMES), .PIN_W(PIN_BITS)) u_ctrl (
    .clk, .rst_n,
    .req_valid(in_tvalid), .req_ready(in_tready),
    .req_mode(in_tdata[2:0]), .req_page(in_tdata[34:3]), .req_dirty(in_tdata[35]),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(r)
  );

  assign out_tdata = {4'd0, r.remove_from_disk, r.zero_fill, r.load_from_disk,
                      r.writeback_page_id, r.writeback_valid, r.was_hit,
                      r.frame_index, r.status};

  `BPFM_ASSERT(a_one_hot_action,
    out_tvalid |-> $countones({r.load_from_disk, r.zero_fill, r.remove_from_disk}) <= 1)
  `BPFM_ASSERT(a_hold_when_stalled,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
endmodule

>>> sv/bpfm_frame_mem.sv
// Frame table memory: tag, dirty, pins and age per frame, one read and one write port.
// Depends on bpfm_pkg.
module bpfm_frame_mem
  import bpfm_pkg::*;
#(
  parameter int FRAMES = POOL_FRAMES_DEF,
  parameter int PIN_W = PIN_BITS_DEF,
  parameter int AW = $clog2(FRAMES)
) (
  input  logic                   clk,
  input  logic [AW-1:0]          rd_addr,
  output logic [PAGE_W-1:0]      rd_tag,
  output logic                   rd_dirty,
  output logic [PIN_W-1:0]       rd_pins,
  output logic [AW-1:0]          rd_age,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [PAGE_W-1:0]      wr_tag,
  input  logic                   wr_dirty,
  input  logic [PIN_W-1:0]       wr_pins,
  input  logic [AW-1:0]          wr_age
);
  localparam int EW = PAGE_W + 1 + PIN_W + AW;
  logic [EW-1:0] mem [FRAMES];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_dirty, wr_pins, wr_age};
    end
    rd_q <= mem[rd_addr];
  end

  assign {rd_tag, rd_dirty, rd_pins, rd_age} = rd_q;
endmodule

>>> sv/bpfm_ctrl.sv
// Sequencer: scans the frame table for lookup and victim, then sweeps it to update ranks.
// Depends on bpfm_pkg, bpfm_frame_mem and the assertion macro header.
`include "buffer_pool_frame_manager_top_assert.svh"
module bpfm_ctrl
  import bpfm_pkg::*;
#(
  parameter int FRAMES = POOL_FRAMES_DEF,
  parameter int PIN_W = PIN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [MODE_W-1:0]   req_mode,
  input  logic [PAGE_W-1:0]   req_page,
  input  logic                req_dirty,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res
);
  localparam int AW = $clog2(FRAMES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST = CW'(FRAMES);
  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  state_t state_r, state_nxt;
  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic mdirty_r, mdirty_nxt;
  logic hit_r, hit_nxt;
  logic [AW-1:0] hidx_r, hidx_nxt;
  logic empty_r, empty_nxt;
  logic [AW-1:0] eidx_r, eidx_nxt;
  logic lru_r, lru_nxt;
  logic [AW-1:0] lidx_r, lidx_nxt;
  logic [AW-1:0] lage_r, lage_nxt;
  // Target frame, its old rank, and the rank shift applied to the others.
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [AW-1:0] tage_r, tage_nxt;
  logic tvalid_r, tvalid_nxt;
  logic do_remove_r, do_remove_nxt;
  logic do_push_r, do_push_nxt;
  logic [PAGE_W-1:0] ttag_r, ttag_nxt;
  logic tdirty_r, tdirty_nxt;
  logic [PIN_W-1:0] tpins_r, tpins_nxt;
  logic tgt_wr_r, tgt_wr_nxt;
  logic [AW-1:0] tnew_age_r, tnew_age_nxt;
  logic tnew_valid_r, tnew_valid_nxt;
  result_t res_r, res_nxt;

  logic [AW-1:0] rd_addr;
  logic [PAGE_W-1:0] rd_tag;
  logic rd_dirty;
  logic [PIN_W-1:0] rd_pins;
  logic [AW-1:0] rd_age;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [PAGE_W-1:0] wr_tag;
  logic wr_dirty;
  logic [PIN_W-1:0] wr_pins;
  logic [AW-1:0] wr_age;

  bpfm_frame_mem #(.FRAMES(FRAMES), .PIN_W(PIN_W)) u_mem (
    .clk, .rd_addr, .rd_tag, .rd_dirty, .rd_pins, .rd_age,
    .wr_en, .wr_addr, .wr_tag, .wr_dirty, .wr_pins, .wr_age
  );

  // Index of the entry whose read data is on rd_* this cycle.
  logic [AW-1:0] pidx;
  logic pvalid;
  logic [AW-1:0] age_adj;
  assign pidx = AW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; page_r <= page_nxt; mdirty_r <= mdirty_nxt;
    hit_r <= hit_nxt; hidx_r <= hidx_nxt; empty_r <= empty_nxt; eidx_r <= eidx_nxt;
    lru_r <= lru_nxt; lidx_r <= lidx_nxt; lage_r <= lage_nxt;
    tgt_r <= tgt_nxt; tage_r <= tage_nxt; tvalid_r <= tvalid_nxt;
    do_remove_r <= do_remove_nxt; do_push_r <= do_push_nxt;
    ttag_r <= ttag_nxt; tdirty_r <= tdirty_nxt; tpins_r <= tpins_nxt;
    tgt_wr_r <= tgt_wr_nxt; tnew_age_r <= tnew_age_nxt; tnew_valid_r <= tnew_valid_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r; valid_nxt = valid_r; cnt_nxt = cnt_r;
    mode_nxt = mode_r; page_nxt = page_r; mdirty_nxt = mdirty_r;
    hit_nxt = hit_r; hidx_nxt = hidx_r; empty_nxt = empty_r; eidx_nxt = eidx_r;
    lru_nxt = lru_r; lidx_nxt = lidx_r; lage_nxt = lage_r;
    tgt_nxt = tgt_r; tage_nxt = tage_r; tvalid_nxt = tvalid_r;
    do_remove_nxt = do_remove_r; do_push_nxt = do_push_r;
    ttag_nxt = ttag_r; tdirty_nxt = tdirty_r; tpins_nxt = tpins_r;
    tgt_wr_nxt = tgt_wr_r; tnew_age_nxt = tnew_age_r; tnew_valid_nxt = tnew_valid_r;
    res_nxt = res_r;
    rd_addr = '0;
    wr_en = 1'b0; wr_addr = pidx; wr_tag = rd_tag; wr_dirty = rd_dirty;
    wr_pins = rd_pins; wr_age = rd_age;
    req_ready = 1'b0;
    pvalid = valid_r[pidx];
    age_adj = rd_age;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          mode_nxt = req_mode; page_nxt = req_page; mdirty_nxt = req_dirty;
          hit_nxt = 1'b0; empty_nxt = 1'b0; lru_nxt = 1'b0;
          hidx_nxt = '0; eidx_nxt = '0; lidx_nxt = '0; lage_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read address cnt_r now; data of cnt_r-1 is on the read port.
        rd_addr = AW'(cnt_r);
        if (cnt_r != '0) begin
          if (pvalid && rd_tag == page_r && !hit_r) begin
            hit_nxt = 1'b1; hidx_nxt = pidx;
            ttag_nxt = rd_tag; tdirty_nxt = rd_dirty; tpins_nxt = rd_pins;
            tage_nxt = rd_age;
          end
          if (!pvalid && !empty_r) begin
            empty_nxt = 1'b1; eidx_nxt = pidx;
          end
          if (pvalid && rd_pins == '0 && (!lru_r || rd_age > lage_r)) begin
            lru_nxt = 1'b1; lidx_nxt = pidx; lage_nxt = rd_age;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // Re-read the victim entry; the result and the update plan are decided here.
        res_nxt = '0;
        do_remove_nxt = 1'b0; do_push_nxt = 1'b0; tgt_wr_nxt = 1'b0;
        tvalid_nxt = 1'b0; tnew_valid_nxt = 1'b0; tnew_age_nxt = '0;
        tgt_nxt = hidx_r;
        rd_addr = empty_r ? eidx_r : lidx_r;
        cnt_nxt = '0;
        state_nxt = S_UPDATE;
        if (mode_r == MODE_FETCH || mode_r == MODE_ALLOC) begin
          if (hit_r) begin
            res_nxt.was_hit = 1'b1;
            res_nxt.frame_index = FIDX_W'(hidx_r);
            if (mode_r == MODE_FETCH) begin
              do_remove_nxt = 1'b1; do_push_nxt = 1'b1; tgt_wr_nxt = 1'b1;
              tvalid_nxt = 1'b1; tnew_valid_nxt = 1'b1;
              if (tpins_r != PIN_MAX) tpins_nxt = tpins_r + PIN_W'(1);
            end else begin
              res_nxt.status = ST_ALREADY;
            end
          end else if (!empty_r && !lru_r) begin
            res_nxt.status = ST_NO_FRAME;
          end else begin
            tgt_nxt = empty_r ? eidx_r : lidx_r;
            res_nxt.frame_index = FIDX_W'(empty_r ? eidx_r : lidx_r);
            tvalid_nxt = !empty_r;
            do_remove_nxt = !empty_r; do_push_nxt = 1'b1; tgt_wr_nxt = 1'b1;
            tnew_valid_nxt = 1'b1;
            tage_nxt = lage_r;
            ttag_nxt = page_r; tdirty_nxt = 1'b0; tpins_nxt = PIN_W'(1);
            res_nxt.load_from_disk = (mode_r == MODE_FETCH);
            res_nxt.zero_fill = (mode_r == MODE_ALLOC);
            // Writeback of the evicted page is filled in by S_UPDATE's first cycle.
          end
        end else if (mode_r == MODE_UNPIN || mode_r == MODE_FLUSH) begin
          if (!hit_r) begin
            res_nxt.status = ST_NOT_RES;
          end else begin
            res_nxt.was_hit = 1'b1;
            res_nxt.frame_index = FIDX_W'(hidx_r);
            tgt_wr_nxt = 1'b1; tvalid_nxt = 1'b1; tnew_valid_nxt = 1'b1;
            tnew_age_nxt = tage_r;
            if (mode_r == MODE_UNPIN) begin
              if (tpins_r != '0) tpins_nxt = tpins_r - PIN_W'(1);
              if (mdirty_r) tdirty_nxt = 1'b1;
            end else if (tdirty_r) begin
              res_nxt.writeback_valid = 1'b1;
              res_nxt.writeback_page_id = page_r;
              tdirty_nxt = 1'b0;
            end
          end
        end else if (mode_r == MODE_DELETE) begin
          if (hit_r) begin
            res_nxt.was_hit = 1'b1;
            res_nxt.frame_index = FIDX_W'(hidx_r);
            if (tpins_r != '0) begin
              res_nxt.status = ST_PINNED;
            end else begin
              do_remove_nxt = 1'b1; tgt_wr_nxt = 1'b1; tvalid_nxt = 1'b1;
              tnew_valid_nxt = 1'b0; tdirty_nxt = 1'b0; tpins_nxt = '0;
              res_nxt.remove_from_disk = 1'b1;
            end
          end
        end
      end
      S_UPDATE: begin
        // Sweep: cnt_r==0 sees the victim read; then frames are read and rewritten as needed.
        rd_addr = AW'(cnt_r);
        if (cnt_r == '0) begin
          if (do_remove_r && !hit_r && rd_dirty) begin
            res_nxt.writeback_valid = 1'b1;
            res_nxt.writeback_page_id = rd_tag;
          end
        end else if (pidx != tgt_r && pvalid) begin
          if (do_remove_r && tvalid_r && rd_age > tage_r) age_adj = age_adj - AW'(1);
          if (do_push_r) age_adj = age_adj + AW'(1);
          wr_en = 1'b1; wr_age = age_adj;
        end else if (pidx == tgt_r && tgt_wr_r) begin
          wr_en = 1'b1; wr_tag = ttag_r; wr_dirty = tdirty_r; wr_pins = tpins_r;
          wr_age = do_push_r ? '0 : tnew_age_r;
          valid_nxt[pidx] = tnew_valid_r;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_valid = (state_r == S_OUT);
  assign res = res_r;

  `BPFM_ASSERT(a_busy_no_accept, (state_r != S_IDLE) |-> !req_ready)
  `BPFM_ASSERT(a_out_after_update, $rose(res_valid) |-> $past(state_r) == S_UPDATE)
  `BPFM_ASSERT(a_wb_only_evict_or_flush,
    res_valid && res.writeback_valid |-> (mode_r == MODE_FETCH || mode_r == MODE_ALLOC
      || mode_r == MODE_FLUSH))
  `BPFM_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE)
endmodule
